// ===== src/insertion_sorter_defines.svh =====
// ----------------------------------------------------------------------------
// insertion_sorter_defines: assertion macros
// Shared macros for concurrent checks. The user's scope needs clk and rst.
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

// same-cycle implication
`define ISORT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ISORT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/isort_pkg.sv =====
// ----------------------------------------------------------------------------
// isort_pkg: insertion sorter types
// Key and result types and the control bundle shared by the cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package isort_pkg;

  localparam int KEY_W = 32;
  localparam int POS_W = 4;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [POS_W-1:0]        pos_t;

  typedef struct packed {
    logic insert;  // accepted key goes into the chain
    logic drain;   // every cell takes its right neighbor
  } cell_ctrl_t;

endpackage

// ===== src/isort_if.sv =====
// ----------------------------------------------------------------------------
// isort_if: request and result channels
// Valid/ready channels for keys in and sorted keys out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface isort_req_if import isort_pkg::*; ();
  logic valid;
  logic ready;
  key_t key_in;
  logic set_end;

  modport source (output valid, output key_in, output set_end, input ready);
  modport sink   (input valid, input key_in, input set_end, output ready);
endinterface

interface isort_rsp_if import isort_pkg::*; ();
  logic valid;
  logic ready;
  key_t key_out;
  pos_t position;
  logic final_out;
  logic overflow;

  modport source (output valid, output key_out, output position, output final_out,
                  output overflow, input ready);
  modport sink   (input valid, input key_out, input position, input final_out,
                  input overflow, output ready);
endinterface

// ===== src/isort_cell.sv =====
// ----------------------------------------------------------------------------
// isort_cell: one slot of the sorting chain
// Holds one key. On insert it takes its left neighbor's key if that one is
// greater than the new key, else the new key if its own is greater (or the
// slot is empty). On drain it takes its right neighbor's key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isort_cell import isort_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  key_t       new_key,
  input  logic       occupied,
  input  key_t       left_key,
  input  logic       left_gt,
  input  key_t       right_key,
  output key_t       key,
  output logic       gt
);

  assign gt = !occupied || (key > new_key);

  always_ff @(posedge clk) begin
    if (ctrl.drain) begin
      key <= right_key;
    end else if (ctrl.insert) begin
      if (left_gt) begin
        key <= left_key;
      end else if (gt) begin
        key <= new_key;
      end
    end
  end

endmodule

// ===== src/insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter: stable insertion sorter, chain of compare cells
// Accepts one key per cycle while collecting a set; every cell compares at once.
// After the key marking set end, results follow from the next cycle, one per
// cycle while the receiver is ready; no request is taken while they drain.
// Synchronous reset empties the chain and clears the overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module insertion_sorter import isort_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  isort_req_if.sink   req_ch,
  isort_rsp_if.source rsp_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count;
  logic             draining;
  logic             dropped;
  pos_t             pos;

  key_t             keys [CAPACITY];
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] occ;
  cell_ctrl_t       ctrl;

  logic req_acc;
  logic rsp_acc;
  logic full;
  logic last;

  assign req_acc = req_ch.valid && req_ch.ready;
  assign rsp_acc = rsp_ch.valid && rsp_ch.ready;
  assign full    = (count == CNT_W'(CAPACITY));
  assign last    = (count == CNT_W'(1));

  assign ctrl.insert = req_acc && !full;
  assign ctrl.drain  = rsp_acc;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t left_key;
    logic left_gt;
    key_t right_key;

    assign occ[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_key = req_ch.key_in;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_key = keys[i-1];
      assign left_gt  = gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = keys[i];
    end else begin : g_inner
      assign right_key = keys[i+1];
    end

    isort_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_key   (req_ch.key_in),
      .occupied  (occ[i]),
      .left_key  (left_key),
      .left_gt   (left_gt),
      .right_key (right_key),
      .key       (keys[i]),
      .gt        (gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      draining <= 1'b0;
      dropped  <= 1'b0;
      pos      <= '0;
    end else begin
      if (req_acc) begin
        if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
        if (req_ch.set_end) begin
          draining <= 1'b1;
        end
      end
      if (rsp_acc) begin
        count <= count - CNT_W'(1);
        pos   <= pos + POS_W'(1);
        if (last) begin
          draining <= 1'b0;
          dropped  <= 1'b0;
          pos      <= '0;
        end
      end
    end
  end

  assign req_ch.ready     = !draining;
  assign rsp_ch.valid     = draining;
  assign rsp_ch.key_out   = keys[0];
  assign rsp_ch.position  = pos;
  assign rsp_ch.final_out = last;
  assign rsp_ch.overflow  = dropped;

endmodule

// ===== src/isort_chk.sv =====
// ----------------------------------------------------------------------------
// isort_chk: port-level checks for the insertion sorter
// Watches both channels and is bound to every sorter instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "insertion_sorter_defines.svh"

module isort_chk import isort_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic set_end,
  input logic rsp_valid,
  input logic rsp_ready,
  input pos_t position,
  input logic final_out
);

  logic req_acc;
  logic rsp_acc;

  assign req_acc = req_valid && req_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  `ISORT_ASSERT_NXT(a_set_end_drains, req_acc && set_end, rsp_valid, "no results after set end")
  `ISORT_ASSERT_IMP(a_no_req_in_drain, rsp_valid, !req_ready, "request taken while draining")
  `ISORT_ASSERT_NXT(a_final_ends, rsp_acc && final_out, !rsp_valid && position == '0, "drain overran")
  `ISORT_ASSERT_NXT(a_rank_steps, rsp_acc && !final_out, rsp_valid && position == POS_W'($past(position) + POS_W'(1)), "rank skipped")

endmodule

bind insertion_sorter isort_chk u_isort_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_ch.valid),
  .req_ready (req_ch.ready),
  .set_end   (req_ch.set_end),
  .rsp_valid (rsp_ch.valid),
  .rsp_ready (rsp_ch.ready),
  .position  (rsp_ch.position),
  .final_out (rsp_ch.final_out)
);

// ===== tb/isort_checker.sv =====
// ----------------------------------------------------------------------------
// isort_checker: result predictor and scoreboard for the insertion sorter
// Watches the key and result channels. Every accepted key goes into a
// private sorted store; a key that ends a set releases the whole set in
// ascending order. Each accepted result is compared, field by field, with
// the oldest release still awaited.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isort_checker import isort_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  isort_req_if req_mon,
  isort_rsp_if rsp_mon,
  output int   mismatches,
  output int   pending
);

  typedef struct {
    key_t key;
    pos_t rank;
    logic last;
    logic lost;
  } sorted_rec_t;

  key_t        held_keys[CAPACITY];
  int          held_count;
  logic        lost_key;
  sorted_rec_t awaited[$];

  // stable insert: only strictly greater entries move up
  task automatic take_key(input key_t k, input logic last);
    int          slot;
    sorted_rec_t rec;
    if (held_count < CAPACITY) begin
      slot = held_count;
      while (slot > 0 && held_keys[slot-1] > k) begin
        held_keys[slot] = held_keys[slot-1];
        slot--;
      end
      held_keys[slot] = k;
      held_count++;
    end else begin
      lost_key = 1'b1;
    end
    if (last) begin
      for (int i = 0; i < held_count; i++) begin
        rec.key  = held_keys[i];
        rec.rank = pos_t'(i);
        rec.last = (i == held_count - 1);
        rec.lost = lost_key;
        awaited.push_back(rec);
      end
      held_count = 0;
      lost_key   = 1'b0;
    end
  endtask

  task automatic check_sorted();
    sorted_rec_t want;
    if (awaited.size() == 0) begin
      $error("unexpected result: key_out=%0d position=%0d", rsp_mon.key_out,
             rsp_mon.position);
      mismatches++;
      return;
    end
    want = awaited.pop_front();
    if (rsp_mon.key_out !== want.key) begin
      $error("key_out: expected %0d, got %0d", want.key, rsp_mon.key_out);
      mismatches++;
    end
    if (rsp_mon.position !== want.rank) begin
      $error("position: expected %0d, got %0d", want.rank, rsp_mon.position);
      mismatches++;
    end
    if (rsp_mon.final_out !== want.last) begin
      $error("final_out: expected %0b, got %0b", want.last, rsp_mon.final_out);
      mismatches++;
    end
    if (rsp_mon.overflow !== want.lost) begin
      $error("overflow: expected %0b, got %0b", want.lost, rsp_mon.overflow);
      mismatches++;
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      lost_key   = 1'b0;
      awaited.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) check_sorted();
      if (req_mon.valid && req_mon.ready) take_key(req_mon.key_in, req_mon.set_end);
    end
    pending <= awaited.size();
  end

endmodule

// ===== tb/insertion_sorter_tb.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter_tb: stimulus and verdict for the insertion sorter
// Directed sets (single keys, extremes, duplicates, a set past capacity
// whose closing key is dropped), then random sets of mixed sizes and keys.
// Both channels idle at random; once the result side holds off long enough
// to back the key channel up, and the sender drains results now and then.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module insertion_sorter_tb;
  import isort_pkg::*;

  localparam int CAP         = 16;
  localparam int ITEMS       = 415;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   pending;
  int   sent;
  int   idle_cycles;
  bit   quiet;
  bit   hold_rsp;

  isort_req_if key_ch ();
  isort_rsp_if sorted_ch ();

  insertion_sorter #(.CAPACITY(CAP)) dut (
    .clk    (clk),
    .rst    (rst),
    .req_ch (key_ch),
    .rsp_ch (sorted_ch)
  );

  isort_checker #(.CAPACITY(CAP)) chk (
    .clk        (clk),
    .rst        (rst),
    .req_mon    (key_ch),
    .rsp_mon    (sorted_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic key_t pick_key();
    case ($urandom_range(0, 9))
      0:       return key_t'(32'h8000_0000);
      1:       return key_t'(32'h7fff_ffff);
      2, 3, 4: return key_t'($urandom_range(0, 8)) - 4;
      default: return key_t'($urandom);
    endcase
  endfunction

  task automatic offer_key(input key_t k, input logic last);
    int gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      key_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_ch.valid   <= 1'b1;
    key_ch.key_in  <= k;
    key_ch.set_end <= last;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic offer_set(input int size);
    for (int i = 0; i < size; i++) offer_key(pick_key(), i == size - 1);
  endtask

  // call at an accept edge; valid is lowered there
  task automatic wait_drained();
    key_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin
    int stall;
    sorted_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        sorted_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = quiet ? 0 : idle_len();
        if (stall > 0) begin
          sorted_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      sorted_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (key_ch.valid && key_ch.ready) || (sorted_ch.valid && sorted_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int sets;
    int size;
    int pick;
    key_ch.valid   <= 1'b0;
    key_ch.key_in  <= '0;
    key_ch.set_end <= 1'b0;
    sent     = 0;
    sets     = 0;
    quiet    = 1'b0;
    hold_rsp = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // single-key sets at both extremes
    offer_key(key_t'(32'h8000_0000), 1'b1);
    offer_key(key_t'(32'h7fff_ffff), 1'b1);
    // extremes and neighbors of zero, unsorted
    offer_key(key_t'(32'h7fff_ffff), 1'b0);
    offer_key(key_t'(32'h8000_0000), 1'b0);
    offer_key(key_t'(0), 1'b0);
    offer_key(key_t'(-1), 1'b0);
    offer_key(key_t'(1), 1'b1);
    // full store, descending with duplicates; closing key is dropped
    for (int i = 0; i < CAP; i++) offer_key(key_t'((CAP - 1 - i) / 2), 1'b0);
    offer_key(key_t'(-5), 1'b1);
    wait_drained();

    while (sent < ITEMS) begin
      quiet = ($urandom_range(0, 4) == 0);
      if (sets == 8) begin
        // long result hold: a full set, then a set that backs up behind it
        quiet = 1'b0;
        hold_rsp = 1'b1;
        while (hold_rsp) @(posedge clk);
        offer_set(CAP);
        offer_set(5);
        wait_drained();
      end else begin
        pick = $urandom_range(0, 9);
        case (pick)
          0:       size = 1;
          7:       size = CAP;
          8:       size = CAP + $urandom_range(1, 4);
          9:       size = $urandom_range(1, 3);
          default: size = $urandom_range(2, CAP - 1);
        endcase
        offer_set(size);
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
      sets++;
    end

    quiet = 1'b0;
    wait_drained();
    repeat (CAP + 10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
